// File: sv/brr_pkg.sv
package brr_pkg;

  // Pixel layout: four 8-bit channels, R in the low byte up to A in the high byte.
  localparam int unsigned PIX_W  = 32;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_CH = 4;

  // Fixed point of the source coordinate and the blend weights.
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned WGT_W  = 8;

  // Four neighbors: top-left, top-right, bottom-left, bottom-right.
  localparam int unsigned NUM_NBR = 4;
  typedef logic [NUM_NBR-1:0][PIX_W-1:0] pix4_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage

// File: sv/brr_div.sv
module brr_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  // Restoring divider, one quotient bit per cycle. The caller guarantees
  // num_i < den_i << QW, so the upper quotient bits are zero and skipped.
  localparam int unsigned CNT_W = $clog2(QW);

  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    sh_q, sh_d;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      cand;
  logic [DW:0]      diff;
  logic             ge;

  always_comb begin
    cand = {rem_q, sh_q[QW-1]};
    diff = cand - {1'b0, den_q};
    ge   = (cand >= {1'b0, den_q});
    rem_d = ge ? diff[DW-1:0] : cand[DW-1:0];
    sh_d  = {sh_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse done for one cycle after the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(QW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(num_i[NW-1:QW]);
      sh_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// File: sv/brr_axis.sv
module brr_axis #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [$clog2(MAX_SIDE)-1:0]   coord_i,
  input  logic [$clog2(MAX_SIDE):0]     src_i,
  input  logic [$clog2(MAX_SIDE):0]     dst_i,
  output logic                          done_o,
  output logic [$clog2(MAX_SIDE)-1:0]   i0_o,
  output logic [$clog2(MAX_SIDE)-1:0]   i1_o,
  output logic [brr_pkg::WGT_W-1:0]     w_o
);

  import brr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned NW = 2 * SW + FRAC_W;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned QW = SW + FRAC_W;
  localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_W - 1);

  logic [2*SW-1:0] prod;
  logic [NW-1:0]   num;
  logic [DW-1:0]   den;
  logic            div_done;
  logic [QW-1:0]   quo;
  logic [QW-1:0]   s;
  logic [SW-1:0]   ip;
  logic [SW-1:0]   last;
  logic [SW-1:0]   ip_cl;
  logic [SW-1:0]   nxt;
  logic [SW-1:0]   i1;
  logic            done_q;
  logic [CW-1:0]   i0_q, i1_q;
  logic [WGT_W-1:0] w_q;

  // (2d+1)*src scaled by 2^16, over 2*dst.
  assign prod = (2*SW)'({coord_i, 1'b1}) * (2*SW)'(src_i);
  assign num  = {prod, {FRAC_W{1'b0}}};
  assign den  = {dst_i, 1'b0};

  brr_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Shift by half a pixel, clamp below at 0, clamp both neighbors to the edge.
  always_comb begin
    s     = (quo >= HALF) ? (quo - HALF) : '0;
    ip    = s[QW-1:FRAC_W];
    last  = src_i - 1'b1;
    ip_cl = (ip > last) ? last : ip;
    nxt   = ip_cl + 1'b1;
    i1    = (nxt < src_i) ? nxt : last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      i0_q <= ip_cl[CW-1:0];
      i1_q <= i1[CW-1:0];
      w_q  <= s[FRAC_W-1:FRAC_W-WGT_W];
    end
  end

  assign done_o = done_q;
  assign i0_o   = i0_q;
  assign i1_o   = i1_q;
  assign w_o    = w_q;

endmodule

// File: sv/brr_store.sv
module brr_store #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic                                    re_i,
  input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    addr_i,
  input  logic [brr_pkg::PIX_W-1:0]               wdata_i,
  output logic [brr_pkg::PIX_W-1:0]               rdata_o
);

  import brr_pkg::*;

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Single port: a write takes the cycle, otherwise a read returns next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/brr_blend.sv
module brr_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  brr_pkg::pix4_t              pix_i,
  input  logic [brr_pkg::WGT_W-1:0]   wx_i,
  input  logic [brr_pkg::WGT_W-1:0]   wy_i,
  output logic                        done_o,
  output logic [brr_pkg::PIX_W-1:0]   rgba_o
);

  import brr_pkg::*;

  localparam int unsigned TW = CH_W + WGT_W;
  localparam int unsigned VW = TW + WGT_W + 1;
  localparam int unsigned RW = VW - 2 * WGT_W;
  localparam logic [RW-1:0] CH_MAX = RW'((1 << CH_W) - 1);

  logic [WGT_W:0]                nwx, nwy;
  logic [NUM_CH-1:0][TW-1:0]     top_d, bot_d;
  logic [NUM_CH-1:0][TW-1:0]     top_q, bot_q;
  logic [PIX_W-1:0]              rgba_d;
  logic [PIX_W-1:0]              rgba_q;
  logic                          vld1_q;
  logic                          done_q;

  assign nwx = (WGT_W+1)'(1 << WGT_W) - {1'b0, wx_i};
  assign nwy = (WGT_W+1)'(1 << WGT_W) - {1'b0, wy_i};

  // Horizontal pass: top and bottom rows per channel.
  always_comb begin
    logic [TW:0] t;
    logic [TW:0] b;
    for (int c = 0; c < NUM_CH; c++) begin
      t = (TW+1)'(pix_i[0][c*CH_W +: CH_W]) * (TW+1)'(nwx)
        + (TW+1)'(pix_i[1][c*CH_W +: CH_W]) * (TW+1)'(wx_i);
      b = (TW+1)'(pix_i[2][c*CH_W +: CH_W]) * (TW+1)'(nwx)
        + (TW+1)'(pix_i[3][c*CH_W +: CH_W]) * (TW+1)'(wx_i);
      top_d[c] = t[TW-1:0];
      bot_d[c] = b[TW-1:0];
    end
  end

  // Vertical pass, truncate and clamp to one channel.
  always_comb begin
    logic [VW-1:0] v;
    logic [RW-1:0] r;
    for (int c = 0; c < NUM_CH; c++) begin
      v = VW'(top_q[c]) * VW'(nwy) + VW'(bot_q[c]) * VW'(wy_i);
      r = v[VW-1:2*WGT_W];
      if (r > CH_MAX) begin
        r = CH_MAX;
      end
      rgba_d[c*CH_W +: CH_W] = r[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      done_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
    if (vld1_q) begin
      rgba_q <= rgba_d;
    end
  end

  assign done_o = done_q;
  assign rgba_o = rgba_q;

endmodule

// File: sv/bilinear_rgba_resizer.sv
// Bilinear RGBA resizer with half-pixel centers.
// Input channel (in_valid_i / in_stall_o): command_i 0 loads pixel_rgba_i into
// the source store at (pos_x_i, pos_y_i); command_i 1 samples destination
// pixel (pos_x_i, pos_y_i). Output channel (out_valid_o / out_stall_i) carries
// one beat per sample and one per rejected load: out_rgba_o, out_x_o, out_y_o
// and range_error_o. Positions outside the configured size give range_error_o
// high and a zero pixel; an in-range load gives no beat.
// Config channel (cfg_valid_i / cfg_ready_o) writes src/dst width and height;
// a value of 0 acts as 1 and a value above MAX_SIDE acts as MAX_SIDE. Write
// only while the block is idle.
// One item is worked at a time. An in-range load is written to the store in DECODE.
// For a sample, the source coordinate is found by a divider that retires one
// quotient bit per cycle, then four neighbors are read one per cycle from
// the single-port store, then a two-stage blend. A finished beat waits in
// the output register; while the receiver stalls, the next item is still
// taken and runs up to its result.
// Reset returns all sizes to 1 and empties the output register; the source
// store is not cleared and holds garbage until loaded.
module bilinear_rgba_resizer #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [$clog2(MAX_SIDE)-1:0]       pos_x_i,
  input  logic [$clog2(MAX_SIDE)-1:0]       pos_y_i,
  input  logic [brr_pkg::PIX_W-1:0]         pixel_rgba_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [brr_pkg::PIX_W-1:0]         out_rgba_o,
  output logic [$clog2(MAX_SIDE)-1:0]       out_x_o,
  output logic [$clog2(MAX_SIDE)-1:0]       out_y_o,
  output logic                              range_error_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [brr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [$clog2(MAX_SIDE):0]         cfg_data_i
);

  import brr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);
  localparam logic [SW-1:0] SIDE_ONE = SW'(1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_BLEND  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;

  // size registers
  logic [SW-1:0]    src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SW-1:0]    cfg_sat;

  // item held while it is worked
  logic             cmd_q;
  logic [CW-1:0]    x_q, y_q;
  logic [PIX_W-1:0] pix_in_q;
  logic             err_q, err_d;

  // neighbor fetch
  logic [1:0]       rd_cnt_q;
  logic             cap_vld_q;
  logic [1:0]       cap_idx_q;
  pix4_t            nbr_q;
  logic             blend_go_q;

  // coordinate mapping
  logic             map_start;
  logic             xm_done, ym_done;
  logic [CW-1:0]    x0, x1, y0, y1;
  logic [WGT_W-1:0] wx, wy;

  // store port
  logic             st_we, st_re;
  logic [CW-1:0]    st_col, st_row;
  logic [AW-1:0]    st_addr;
  logic [PIX_W-1:0] st_rdata;

  // blend
  logic             blend_done;
  logic [PIX_W-1:0] blend_rgba;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_rgba_q;
  logic [CW-1:0]    out_x_q, out_y_q;
  logic             out_err_q;
  logic             out_load;

  logic             in_accept;
  logic             load_ok;
  logic             samp_ok;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, saturate the written size into 1..MAX_SIDE.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_sat = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_sat = SIDE_ONE;
    end else if (cfg_data_i > SIDE_MAX) begin
      cfg_sat = SIDE_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SIDE_ONE;
      src_h_q <= SIDE_ONE;
      dst_w_q <= SIDE_ONE;
      dst_h_q <= SIDE_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:  src_w_q <= cfg_sat;
        CFG_SRC_HEIGHT: src_h_q <= cfg_sat;
        CFG_DST_WIDTH:  dst_w_q <= cfg_sat;
        CFG_DST_HEIGHT: dst_h_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item intake and range checks.
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign load_ok = (SW'(x_q) < src_w_q) && (SW'(y_q) < src_h_q);
  assign samp_ok = (SW'(x_q) < dst_w_q) && (SW'(y_q) < dst_h_q);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= command_i;
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      pix_in_q <= pixel_rgba_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Source coordinate of each axis.
  // ---------------------------------------------------------------------------
  assign map_start = (state_q == ST_DECODE) && (cmd_q == CMD_SAMPLE) && samp_ok;

  brr_axis #(
    .MAX_SIDE (MAX_SIDE)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .coord_i (x_q),
    .src_i   (src_w_q),
    .dst_i   (dst_w_q),
    .done_o  (xm_done),
    .i0_o    (x0),
    .i1_o    (x1),
    .w_o     (wx)
  );

  brr_axis #(
    .MAX_SIDE (MAX_SIDE)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .coord_i (y_q),
    .src_i   (src_h_q),
    .dst_i   (dst_h_q),
    .done_o  (ym_done),
    .i0_o    (y0),
    .i1_o    (y1),
    .w_o     (wy)
  );

  // ---------------------------------------------------------------------------
  // Source store: loads write in DECODE, samples read four neighbors in READ.
  // Read order: top-left, top-right, bottom-left, bottom-right.
  // ---------------------------------------------------------------------------
  assign st_we = (state_q == ST_DECODE) && (cmd_q == CMD_LOAD) && load_ok;
  assign st_re = (state_q == ST_READ);

  always_comb begin
    if (state_q == ST_READ) begin
      st_col = rd_cnt_q[0] ? x1 : x0;
      st_row = rd_cnt_q[1] ? y1 : y0;
    end else begin
      st_col = x_q;
      st_row = y_q;
    end
  end

  assign st_addr = AW'(st_row) * AW'(MAX_SIDE) + AW'(st_col);

  brr_store #(
    .MAX_SIDE (MAX_SIDE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .re_i    (st_re),
    .addr_i  (st_addr),
    .wdata_i (pix_in_q),
    .rdata_o (st_rdata)
  );

  // Capture each neighbor in the cycle after its read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_vld_q  <= 1'b0;
      blend_go_q <= 1'b0;
    end else begin
      cap_vld_q  <= st_re;
      blend_go_q <= (state_q == ST_FILL);
    end
  end

  always_ff @(posedge clk_i) begin
    cap_idx_q <= rd_cnt_q;
    if (cap_vld_q) begin
      nbr_q[cap_idx_q] <= st_rdata;
    end
  end

  brr_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_go_q),
    .pix_i   (nbr_q),
    .wx_i    (wx),
    .wy_i    (wy),
    .done_o  (blend_done),
    .rgba_o  (blend_rgba)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (cmd_q == CMD_LOAD) begin
          // an in-range load is done once written; a rejected one reports
          err_d   = 1'b1;
          state_d = load_ok ? ST_IDLE : ST_DONE;
        end else if (samp_ok) begin
          err_d   = 1'b0;
          state_d = ST_MAP;
        end else begin
          err_d   = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_MAP: begin
        if (xm_done && ym_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (blend_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      err_q    <= 1'b0;
      rd_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else begin
        rd_cnt_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: drop valid when the beat is taken, refill from DONE.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rgba_q <= err_q ? '0 : blend_rgba;
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_rgba_o    = out_rgba_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign range_error_o = out_err_q;

endmodule
